@@ hdl/text_segment_quality_filter_assert.svh @@
// Assertion macros used by the checker file of the text segment quality filter.
`ifndef TEXT_SEGMENT_QUALITY_FILTER_ASSERT_SVH
`define TEXT_SEGMENT_QUALITY_FILTER_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define TSQF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("tsqf check failed");

// Antecedent implies consequent in the next cycle.
`define TSQF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("tsqf check failed");

`endif

@@ hdl/tsqf_pkg.sv @@
// Shared types and constants of the text segment quality filter.
package tsqf_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int GUARD_BITS = 16;
    localparam int NB         = FRAC_BITS + GUARD_BITS;
    localparam int CW         = 17;
    localparam int DW         = 35;
    localparam int QDEPTH     = 4;
    localparam int QAW        = $clog2(QDEPTH);

    localparam logic [CW-1:0] SEG_MAX = CW'(65536);
    localparam logic [CW-1:0] ONE_Q   = CW'(1 << FRAC_BITS);
    localparam logic [7:0]    SPACE_B = 8'h20;

    // Full-scale points of the length and word sub-scores
    localparam int LEN_FULL   = 240;
    localparam int WORDS_FULL = 40;

    // Reciprocal constants for the fixed-divisor sub-scores and the final scale
    localparam logic [24:0] LEN_K    = 25'd17895697;  // (2^28 - 1) / 15
    localparam logic [7:0]  LEN_R15  = 8'd137;        // about 2^11 / 15
    localparam logic [26:0] WORDS_K  = 27'd107374182; // (2^29 - 2) / 5
    localparam logic [7:0]  WORDS_R5 = 8'd205;        // about 2^10 / 5
    localparam logic [19:0] SCORE_R5 = 20'd838861;    // ceil(2^22 / 5)

    // Register indexes
    localparam logic [1:0] REG_MIN_CHARS = 2'd0;
    localparam logic [1:0] REG_MIN_WORDS = 2'd1;
    localparam logic [1:0] REG_MIN_CONF  = 2'd2;
    localparam logic [1:0] REG_MAX_RATIO = 2'd3;

    // Status and reason codes
    localparam logic [1:0] ST_KEPT     = 2'd0;
    localparam logic [1:0] ST_REPAIRED = 2'd1;
    localparam logic [1:0] ST_DISCARD  = 2'd2;
    localparam logic [2:0] RS_NONE     = 3'd0;
    localparam logic [2:0] RS_EMPTY    = 3'd1;
    localparam logic [2:0] RS_SHORT    = 3'd2;
    localparam logic [2:0] RS_LOWCONF  = 3'd3;
    localparam logic [2:0] RS_NOISE    = 3'd4;
    localparam logic [2:0] RS_NOSEM    = 3'd5;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_SUM  = 1'b1;

    typedef struct packed {
        logic [7:0]    in_byte;
        logic          has_byte;
        logic [CW-1:0] confidence;
        logic          seg_last;
    } in_t;

    typedef struct packed {
        logic          kind;
        logic [7:0]    out_byte;
        logic [1:0]    status;
        logic [2:0]    reason;
        logic [CW-1:0] quality;
        logic          last;
    } out_t;

    typedef struct packed {
        logic [CW-1:0] min_chars;
        logic [CW-1:0] min_words;
        logic [CW-1:0] min_conf;
        logic [CW-1:0] max_ratio;
    } cfg_t;

    // One queued work item: optional space, optional byte, optional summary snapshot
    typedef struct packed {
        logic          sp;
        logic          bv;
        logic [7:0]    byte_v;
        logic          last;
        logic          changed;
        logic [CW-1:0] conf;
        logic [CW-1:0] vis;
        logic [CW-1:0] sym;
        logic [CW-1:0] words;
        logic [CW-1:0] letters;
        logic [CW-1:0] longw;
    } entry_t;

endpackage

@@ hdl/tsqf_front.sv @@
// Front end: classifies input bytes, tracks segment counters, pushes work entries.
module tsqf_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  tsqf_pkg::in_t    s_data,
    input  logic             q_full,
    output logic             q_push,
    output tsqf_pkg::entry_t q_entry
);

    logic                    seen_reg, pend_reg, prev_reg, chg_reg;
    logic                    seen_next, pend_next, prev_next, chg_next;
    logic [tsqf_pkg::CW-1:0] vis_reg, sym_reg, words_reg, let_reg, long_reg;
    logic [tsqf_pkg::CW-1:0] vis_next, sym_next, words_next, let_next, long_next;
    logic [1:0]              wl_reg, wl_next;
    logic                    ws, alpha, alnum, sp_emit, accept;
    logic [7:0]              b;

    function automatic logic [tsqf_pkg::CW-1:0] sat_inc(input logic [tsqf_pkg::CW-1:0] c);
        return (c < tsqf_pkg::SEG_MAX) ? c + 1'b1 : c;
    endfunction

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign b       = s_data.in_byte;
    assign ws      = (b == tsqf_pkg::SPACE_B) || (b >= 8'h09 && b <= 8'h0D);
    assign alpha   = (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
    assign alnum   = alpha || (b >= 8'h30 && b <= 8'h39);

    // Per-byte counter update and entry build
    always_comb begin
        seen_next  = seen_reg;
        pend_next  = pend_reg;
        prev_next  = prev_reg;
        chg_next   = chg_reg;
        vis_next   = vis_reg;
        sym_next   = sym_reg;
        words_next = words_reg;
        let_next   = let_reg;
        long_next  = long_reg;
        wl_next    = wl_reg;
        sp_emit    = 1'b0;
        if (s_data.has_byte) begin
            if (ws) begin
                if (b != tsqf_pkg::SPACE_B || prev_reg || !seen_reg) begin
                    chg_next = 1'b1;
                end
                if (seen_reg) begin
                    pend_next = 1'b1;
                end
                prev_next = 1'b1;
                wl_next   = 2'd0;
            end else begin
                sp_emit   = pend_reg;
                pend_next = 1'b0;
                if (!seen_reg || prev_reg) begin
                    words_next = sat_inc(words_reg);
                    wl_next    = 2'd0;
                end
                seen_next = 1'b1;
                prev_next = 1'b0;
                vis_next  = sat_inc(vis_reg);
                if (!alnum) begin
                    sym_next = sat_inc(sym_reg);
                end
                if (alpha) begin
                    let_next = sat_inc(let_reg);
                    if (wl_next != 2'd3) begin
                        wl_next = wl_next + 2'd1;
                        if (wl_next == 2'd3) begin
                            long_next = sat_inc(long_reg);
                        end
                    end
                end
            end
        end

        q_entry.sp      = sp_emit;
        q_entry.bv      = s_data.has_byte && !ws;
        q_entry.byte_v  = b;
        q_entry.last    = s_data.seg_last;
        q_entry.changed = chg_next || prev_next;
        q_entry.conf    = s_data.confidence;
        q_entry.vis     = vis_next;
        q_entry.sym     = sym_next;
        q_entry.words   = words_next;
        q_entry.letters = let_next;
        q_entry.longw   = long_next;
        q_push = accept && (q_entry.bv || s_data.seg_last);

        // Segment close clears all tracking state
        if (s_data.seg_last) begin
            seen_next  = 1'b0;
            pend_next  = 1'b0;
            prev_next  = 1'b0;
            chg_next   = 1'b0;
            vis_next   = '0;
            sym_next   = '0;
            words_next = '0;
            let_next   = '0;
            long_next  = '0;
            wl_next    = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg  <= 1'b0;
            pend_reg  <= 1'b0;
            prev_reg  <= 1'b0;
            chg_reg   <= 1'b0;
            vis_reg   <= '0;
            sym_reg   <= '0;
            words_reg <= '0;
            let_reg   <= '0;
            long_reg  <= '0;
            wl_reg    <= 2'd0;
        end else if (accept) begin
            seen_reg  <= seen_next;
            pend_reg  <= pend_next;
            prev_reg  <= prev_next;
            chg_reg   <= chg_next;
            vis_reg   <= vis_next;
            sym_reg   <= sym_next;
            words_reg <= words_next;
            let_reg   <= let_next;
            long_reg  <= long_next;
            wl_reg    <= wl_next;
        end
    end

endmodule

@@ hdl/tsqf_queue.sv @@
// Short work queue between front end and back end.
module tsqf_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  tsqf_pkg::entry_t push_data,
    input  logic             pop,
    output tsqf_pkg::entry_t pop_data,
    output logic             full,
    output logic             empty
);

    tsqf_pkg::entry_t        slot_reg [tsqf_pkg::QDEPTH];
    logic [tsqf_pkg::QAW-1:0] wptr_reg, rptr_reg;
    logic [tsqf_pkg::QAW:0]   cnt_reg;

    assign full     = (cnt_reg == (tsqf_pkg::QAW+1)'(tsqf_pkg::QDEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_data = slot_reg[rptr_reg];

    // Slot storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wptr_reg] <= push_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            if (push) wptr_reg <= wptr_reg + 1'b1;
            if (pop)  rptr_reg <= rptr_reg + 1'b1;
            if (push && !pop)      cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push) cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

@@ hdl/tsqf_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
module tsqf_div (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [tsqf_pkg::DW-1:0] rem_init,
    input  logic [tsqf_pkg::DW-1:0] den,
    input  logic [tsqf_pkg::NB-1:0] num_bits,
    output logic                    done,
    output logic [tsqf_pkg::NB-1:0] quo
);

    logic [tsqf_pkg::DW-1:0] r_reg, den_reg, r_shift;
    logic [tsqf_pkg::NB-1:0] d_reg, q_reg;
    logic [5:0]              cnt_reg;
    logic                    busy_reg, done_reg, ge;

    assign r_shift = {r_reg[tsqf_pkg::DW-2:0], d_reg[tsqf_pkg::NB-1]};
    assign ge      = (r_shift >= den_reg);
    assign done    = done_reg;
    assign quo     = q_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'(tsqf_pkg::NB);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            r_reg   <= rem_init;
            den_reg <= den;
            d_reg   <= num_bits;
            q_reg   <= '0;
        end else if (busy_reg) begin
            r_reg <= ge ? r_shift - den_reg : r_shift;
            d_reg <= {d_reg[tsqf_pkg::NB-2:0], 1'b0};
            q_reg <= {q_reg[tsqf_pkg::NB-2:0], ge};
        end
    end

endmodule

@@ hdl/tsqf_back.sv @@
// Back end: emits cleaned bytes and computes the segment summary.
module tsqf_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  tsqf_pkg::cfg_t   cfg,
    input  logic             q_empty,
    input  tsqf_pkg::entry_t q_data,
    output logic             q_pop,
    output logic             m_valid,
    input  logic             m_ready,
    output tsqf_pkg::out_t   m_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_SPACE, S_BYTE, S_MUL, S_FSTART, S_FWAIT, S_SUM, S_SCALE, S_EMIT
    } state_t;

    state_t                  state_reg;
    tsqf_pkg::entry_t        ent_reg;
    tsqf_pkg::out_t          out_reg;
    logic                    out_vld_reg;
    logic [33:0]             prod_reg;
    logic [tsqf_pkg::NB:0]   f1_reg, f2_reg, f4_reg;
    logic [tsqf_pkg::CW-1:0] qres_reg;
    logic [19:0]             t_reg;

    logic                    out_free, out_load;
    logic [17:0]             len;
    logic [15:0]             l15, w5;
    logic [33:0]             vm, sm, mn;
    logic [tsqf_pkg::NB:0]   f1c, f2c, f3;
    logic [37:0]             sum;
    logic [tsqf_pkg::DW-1:0] fa, fb;
    logic [tsqf_pkg::NB-1:0] div_q;
    logic                    fsat, fzero, div_start, div_done;
    logic [2:0]              reason;
    logic [39:0]             qprod;
    logic [tsqf_pkg::CW-1:0] qclamp;

    assign out_free = !out_vld_reg || m_ready;
    assign m_valid  = out_vld_reg;
    assign m_data   = out_reg;
    assign q_pop    = (state_reg == S_IDLE) && !q_empty;

    // Output register loads on a space, a byte or the summary
    assign out_load = out_free && (((state_reg == S_SPACE) && ent_reg.sp)
                                || ((state_reg == S_BYTE) && ent_reg.bv)
                                || (state_reg == S_EMIT));

    // Summary datapath
    always_comb begin
        len = (ent_reg.vis == '0) ? 18'd0
            : 18'(ent_reg.vis) + 18'(ent_reg.words) - 18'd1;

        // Length sub-score: len * 2^28 / 15 = len * LEN_K + floor(len / 15)
        l15 = 16'(len[7:0]) * 16'(tsqf_pkg::LEN_R15);
        f1c = (len >= 18'(tsqf_pkg::LEN_FULL))
            ? (tsqf_pkg::NB+1)'(1) << tsqf_pkg::NB
            : (tsqf_pkg::NB+1)'(33'(len[7:0]) * 33'(tsqf_pkg::LEN_K))
              + (tsqf_pkg::NB+1)'(l15[15:11]);

        // Word sub-score: w * 2^29 / 5 = w * WORDS_K + floor(2w / 5)
        w5  = 16'({ent_reg.words[5:0], 1'b0}) * 16'(tsqf_pkg::WORDS_R5);
        f2c = (ent_reg.words >= tsqf_pkg::CW'(tsqf_pkg::WORDS_FULL))
            ? (tsqf_pkg::NB+1)'(1) << tsqf_pkg::NB
            : (tsqf_pkg::NB+1)'(33'(ent_reg.words[5:0]) * 33'(tsqf_pkg::WORDS_K))
              + (tsqf_pkg::NB+1)'(w5[15:10]);

        vm  = (ent_reg.vis == '0) ? 34'(cfg.max_ratio) : prod_reg;
        sm  = (ent_reg.vis == '0) ? 34'(tsqf_pkg::ONE_Q)
            : {1'b0, ent_reg.sym, 16'b0};
        mn  = (sm < vm) ? sm : vm;
        f3  = (ent_reg.conf >= tsqf_pkg::ONE_Q)
            ? (tsqf_pkg::NB+1)'(1) << tsqf_pkg::NB
            : (tsqf_pkg::NB+1)'({ent_reg.conf, 16'b0});

        // Symbol-ratio sub-score goes through the divider unless it saturates or max_ratio is zero
        fa    = tsqf_pkg::DW'(vm - mn);
        fb    = tsqf_pkg::DW'(vm);
        fzero = (cfg.max_ratio == '0);
        fsat  = (fa >= fb);
        sum   = 38'(f1_reg) * 38'd5 + 38'(f2_reg) * 38'd5 + 38'(f3) * 38'd6
              + 38'(f4_reg) * 38'd4 + (38'd10 << tsqf_pkg::GUARD_BITS);

        // Discard tests in priority order
        if (len == '0)
            reason = tsqf_pkg::RS_EMPTY;
        else if (len < 18'(cfg.min_chars) || ent_reg.words < cfg.min_words)
            reason = tsqf_pkg::RS_SHORT;
        else if (ent_reg.conf < cfg.min_conf)
            reason = tsqf_pkg::RS_LOWCONF;
        else if ({1'b0, ent_reg.sym, 16'b0} > prod_reg)
            reason = tsqf_pkg::RS_NOISE;
        else if (ent_reg.letters < 17'd12 || ent_reg.longw < 17'd2)
            reason = tsqf_pkg::RS_NOSEM;
        else
            reason = tsqf_pkg::RS_NONE;

        // Final divide by 5 as a reciprocal multiply, then clamp to 1.0
        qprod  = 40'(t_reg) * 40'(tsqf_pkg::SCORE_R5);
        qclamp = (qprod[39:22] > 18'(tsqf_pkg::ONE_Q))
               ? tsqf_pkg::ONE_Q : qprod[38:22];

        div_start = (state_reg == S_FSTART) && !fsat && !fzero;
    end

    tsqf_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .rem_init (fa),
        .den      (fb),
        .num_bits ('0),
        .done     (div_done),
        .quo      (div_q)
    );

    // Sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            out_vld_reg <= 1'b0;
        end else begin
            if (out_load) out_vld_reg <= 1'b1;
            else if (m_ready) out_vld_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (!q_empty) begin
                        ent_reg   <= q_data;
                        state_reg <= S_SPACE;
                    end
                end
                S_SPACE: begin
                    if (!ent_reg.sp) begin
                        state_reg <= S_BYTE;
                    end else if (out_free) begin
                        out_reg     <= '{tsqf_pkg::KIND_BYTE, tsqf_pkg::SPACE_B,
                                         tsqf_pkg::ST_KEPT, tsqf_pkg::RS_NONE, '0, 1'b0};
                        state_reg   <= S_BYTE;
                    end
                end
                S_BYTE: begin
                    if (!ent_reg.bv) begin
                        state_reg <= ent_reg.last ? S_MUL : S_IDLE;
                    end else if (out_free) begin
                        out_reg     <= '{tsqf_pkg::KIND_BYTE, ent_reg.byte_v,
                                         tsqf_pkg::ST_KEPT, tsqf_pkg::RS_NONE, '0, 1'b0};
                        state_reg   <= ent_reg.last ? S_MUL : S_IDLE;
                    end
                end
                S_MUL: begin
                    prod_reg  <= 34'(cfg.max_ratio) * 34'(ent_reg.vis);
                    f1_reg    <= f1c;
                    f2_reg    <= f2c;
                    state_reg <= S_FSTART;
                end
                S_FSTART: begin
                    if (fsat || fzero) begin
                        f4_reg    <= fzero ? '0 : (tsqf_pkg::NB+1)'(1) << tsqf_pkg::NB;
                        state_reg <= S_SUM;
                    end else begin
                        state_reg <= S_FWAIT;
                    end
                end
                S_FWAIT: begin
                    if (div_done) begin
                        f4_reg    <= {1'b0, div_q};
                        state_reg <= S_SUM;
                    end
                end
                S_SUM: begin
                    t_reg     <= sum[37:18];
                    state_reg <= S_SCALE;
                end
                S_SCALE: begin
                    qres_reg  <= qclamp;
                    state_reg <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        out_reg.kind     <= tsqf_pkg::KIND_SUM;
                        out_reg.out_byte <= 8'd0;
                        out_reg.status   <= (reason != tsqf_pkg::RS_NONE) ? tsqf_pkg::ST_DISCARD
                                          : (ent_reg.changed ? tsqf_pkg::ST_REPAIRED
                                                             : tsqf_pkg::ST_KEPT);
                        out_reg.reason   <= reason;
                        out_reg.quality  <= qres_reg;
                        out_reg.last     <= 1'b1;
                        state_reg        <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

@@ hdl/text_segment_quality_filter.sv @@
// Top level of the text segment quality filter.
//
//   channel | dir | payload                 | handshake
//   s_      | in  | in_t  (byte, confidence) | s_valid / s_ready
//   m_      | out | out_t (byte or summary)  | m_valid / m_ready
//   cfg_    | in  | 17-bit register data     | cfg_wen, no stall
//
// The front end takes one byte per cycle while the 4-entry work queue has room.
// Each queued entry passes the back-end states IDLE, SPACE and BYTE; a segment close
// adds MUL, FSTART, SUM, SCALE, EMIT, and FWAIT for a 32-step symbol-ratio division.
// Reset is synchronous, active low, and needs no clearing pass.
// Either side may stall; the queue and the output register decouple them.
module text_segment_quality_filter (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  tsqf_pkg::in_t           s_data,
    output logic                    m_valid,
    input  logic                    m_ready,
    output tsqf_pkg::out_t          m_data,
    input  logic                    cfg_wen,
    input  logic [1:0]              cfg_index,
    input  logic [tsqf_pkg::CW-1:0] cfg_data
);

    tsqf_pkg::cfg_t   cfg_reg;
    tsqf_pkg::entry_t push_entry, pop_entry;
    logic             q_push, q_pop, q_full, q_empty;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_chars <= tsqf_pkg::CW'(40);
            cfg_reg.min_words <= tsqf_pkg::CW'(5);
            cfg_reg.min_conf  <= tsqf_pkg::CW'(32768);
            cfg_reg.max_ratio <= tsqf_pkg::CW'(22938);
        end else if (cfg_wen) begin
            case (cfg_index)
                tsqf_pkg::REG_MIN_CHARS: cfg_reg.min_chars <= cfg_data;
                tsqf_pkg::REG_MIN_WORDS: cfg_reg.min_words <= cfg_data;
                tsqf_pkg::REG_MIN_CONF:  cfg_reg.min_conf  <= cfg_data;
                tsqf_pkg::REG_MAX_RATIO: cfg_reg.max_ratio <= cfg_data;
                default: ;
            endcase
        end
    end

    tsqf_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_entry (push_entry)
    );

    tsqf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (push_entry),
        .pop       (q_pop),
        .pop_data  (pop_entry),
        .full      (q_full),
        .empty     (q_empty)
    );

    tsqf_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_empty (q_empty),
        .q_data  (pop_entry),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

@@ hdl/tsqf_checker.sv @@
// Port-level checker for the text segment quality filter, with its bind.
`include "text_segment_quality_filter_assert.svh"

module tsqf_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           m_valid,
    input logic           m_ready,
    input tsqf_pkg::out_t m_data
);

    `TSQF_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data))
    `TSQF_ASSERT_NOW(a_byte_clean, m_valid && m_data.kind == tsqf_pkg::KIND_BYTE, m_data.status == tsqf_pkg::ST_KEPT && m_data.quality == '0 && !m_data.last)
    `TSQF_ASSERT_NOW(a_sum_last, m_valid && m_data.kind == tsqf_pkg::KIND_SUM, m_data.last && m_data.quality <= tsqf_pkg::ONE_Q)
    `TSQF_ASSERT_NOW(a_discard, m_valid && m_data.reason != tsqf_pkg::RS_NONE, m_data.status == tsqf_pkg::ST_DISCARD)

endmodule

bind text_segment_quality_filter tsqf_checker u_tsqf_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
